@@ rtl/core/wrs_pkg.sv @@
// shared types, constants and window arithmetic of the weekly relay time switch
package wrs_pkg;

    localparam int RELAYS  = 4;
    localparam int SLOTS   = 4;
    localparam int ENTRIES = RELAYS * SLOTS;
    localparam int RW      = (RELAYS > 1) ? $clog2(RELAYS) : 1;
    localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int MIN_PER_HOUR = 60;
    localparam int MIN_PER_DAY  = 1440;
    localparam int WEEK_DAYS    = 7;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MODE  = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] MODE_FORCE_OFF = 2'd0;
    localparam logic [1:0] MODE_ON        = 2'd1;
    localparam logic [1:0] MODE_SCHEDULED = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  relay;
        logic [1:0]  slot;
        logic [1:0]  mode;
        logic        entry_enabled;
        logic [6:0]  days_mask;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
        logic [4:0]  stop_hour;
        logic [5:0]  stop_minute;
        logic [2:0]  now_day;
        logic [10:0] now_minute_of_day;
    } item_t;

    typedef struct packed {
        logic [3:0]  relay_on;
        logic [3:0]  relay_changed;
        logic        event_valid;
        logic [1:0]  event_relay;
        logic        event_turn_on;
        logic [4:0]  event_hour;
        logic [5:0]  event_minute;
        logic [13:0] event_in_minutes;
    } result_t;

    typedef struct packed {
        logic       en;
        logic [6:0] days;
        logic [4:0] sh;
        logic [5:0] sm;
        logic [4:0] eh;
        logic [5:0] em;
    } entry_t;

    typedef struct packed {
        logic        found;
        logic [13:0] delta;
    } occ_t;

    typedef struct packed {
        logic              done;
        logic [RELAYS-1:0] want;
        logic              ev_valid;
        logic [1:0]        ev_relay;
        logic              ev_on;
        logic [4:0]        ev_hour;
        logic [5:0]        ev_minute;
        logic [13:0]       ev_delta;
    } scan_stat_t;

    function automatic logic [10:0] minute_of(input logic [4:0] h, input logic [5:0] m);
        return 11'(h) * 11'(MIN_PER_HOUR) + 11'(m);
    endfunction

    function automatic logic entry_match(input entry_t e, input logic [2:0] day,
                                         input logic [10:0] now);
        logic [10:0] a;
        logic [10:0] b;
        logic [7:0]  m;
        logic        hit;
        a   = minute_of(e.sh, e.sm);
        b   = minute_of(e.eh, e.em);
        m   = {1'b0, e.days};
        hit = 1'b0;
        if (e.en && m[day] && (a != b))
        begin
            if (a < b)
            begin
                hit = (now >= a) && (now < b);
            end
            else
            begin
                hit = (now >= a) || (now < b);
            end
        end
        return hit;
    endfunction

    // first strictly future minute on a masked day, up to a week ahead
    function automatic occ_t next_occ(input logic [2:0] day, input logic [10:0] now,
                                      input logic [10:0] tgt, input logic [6:0] mask);
        occ_t               o;
        logic [7:0]         m;
        logic [3:0]         sum;
        logic [2:0]         d;
        logic signed [15:0] dk;
        o = '0;
        m = {1'b0, mask};
        for (int k = WEEK_DAYS; k >= 0; k--)
        begin
            sum = 4'(day) + 4'(k);
            if (sum >= 4'(2 * WEEK_DAYS))
            begin
                d = 3'(sum - 4'(2 * WEEK_DAYS));
            end
            else if (sum >= 4'(WEEK_DAYS))
            begin
                d = 3'(sum - 4'(WEEK_DAYS));
            end
            else
            begin
                d = 3'(sum);
            end
            dk = $signed(16'(k * MIN_PER_DAY)) + $signed({5'b0, tgt}) - $signed({5'b0, now});
            if (m[d] && !dk[15] && (dk != 16'sd0))
            begin
                o.found = 1'b1;
                o.delta = 14'(dk);
            end
        end
        return o;
    endfunction

endpackage

@@ rtl/core/wrs_ram.sv @@
// generic simple dual-port ram with registered read
module wrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/wrs_scan.sv @@
// table walk: window match and nearest switch event, one entry per SC_ON/SC_OFF state pair
module wrs_scan import wrs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        day,
    input  logic [10:0]       now,
    input  logic [RELAYS-1:0] auto_mode,
    input  entry_t            rd_entry,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    output scan_stat_t        stat
);

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_READ = 4'b0010,
        SC_ON   = 4'b0100,
        SC_OFF  = 4'b1000
    } scan_state_t;

    scan_state_t   state_reg, state_next;
    logic [RW-1:0] relay_reg, relay_next;
    logic [SW-1:0] slot_reg, slot_next;
    scan_stat_t    stat_reg, stat_next;

    logic [RW-1:0] relay_inc;
    logic [SW-1:0] slot_inc;
    logic [RW-1:0] addr_relay;
    logic [SW-1:0] addr_slot;
    logic [10:0]   a_min;
    logic [10:0]   b_min;
    logic [6:0]    off_mask;
    occ_t          occ;
    logic          live;
    logic          take;
    logic          last;

    always_comb
    begin
        a_min    = minute_of(rd_entry.sh, rd_entry.sm);
        b_min    = minute_of(rd_entry.eh, rd_entry.em);
        off_mask = (a_min > b_min) ? {rd_entry.days[5:0], rd_entry.days[6]} : rd_entry.days;
        occ      = (state_reg == SC_ON) ? next_occ(day, now, a_min, rd_entry.days)
                                        : next_occ(day, now, b_min, off_mask);
        live     = auto_mode[relay_reg] && rd_entry.en && (a_min != b_min);
        take     = live && occ.found && (!stat_reg.ev_valid || (occ.delta < stat_reg.ev_delta));
        last     = (int'(relay_reg) == RELAYS - 1) && (int'(slot_reg) == SLOTS - 1);

        if (int'(slot_reg) == SLOTS - 1)
        begin
            slot_inc  = '0;
            relay_inc = relay_reg + RW'(1);
        end
        else
        begin
            slot_inc  = slot_reg + SW'(1);
            relay_inc = relay_reg;
        end

        addr_relay = (state_reg == SC_OFF) ? relay_inc : relay_reg;
        addr_slot  = (state_reg == SC_OFF) ? slot_inc : slot_reg;
        rd_addr    = AW'(int'(addr_relay) * SLOTS + int'(addr_slot));
        rd_en      = (state_reg == SC_READ) || ((state_reg == SC_OFF) && !last);
    end

    always_comb
    begin
        state_next     = state_reg;
        relay_next     = relay_reg;
        slot_next      = slot_reg;
        stat_next      = stat_reg;
        stat_next.done = 1'b0;
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    stat_next  = '0;
                    relay_next = '0;
                    slot_next  = '0;
                    state_next = SC_READ;
                end
            end
            SC_READ:
            begin
                state_next = SC_ON;
            end
            SC_ON:
            begin
                if (auto_mode[relay_reg] && entry_match(rd_entry, day, now))
                begin
                    stat_next.want[relay_reg] = 1'b1;
                end
                if (take)
                begin
                    stat_next.ev_valid  = 1'b1;
                    stat_next.ev_relay  = 2'(relay_reg);
                    stat_next.ev_on     = 1'b1;
                    stat_next.ev_hour   = rd_entry.sh;
                    stat_next.ev_minute = rd_entry.sm;
                    stat_next.ev_delta  = occ.delta;
                end
                state_next = SC_OFF;
            end
            SC_OFF:
            begin
                if (take)
                begin
                    stat_next.ev_valid  = 1'b1;
                    stat_next.ev_relay  = 2'(relay_reg);
                    stat_next.ev_on     = 1'b0;
                    stat_next.ev_hour   = rd_entry.eh;
                    stat_next.ev_minute = rd_entry.em;
                    stat_next.ev_delta  = occ.delta;
                end
                if (last)
                begin
                    stat_next.done = 1'b1;
                    state_next     = SC_IDLE;
                end
                else
                begin
                    relay_next = relay_inc;
                    slot_next  = slot_inc;
                    state_next = SC_ON;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            relay_reg <= '0;
            slot_reg  <= '0;
            stat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            relay_reg <= relay_next;
            slot_reg  <= slot_next;
            stat_reg  <= stat_next;
        end
    end

    assign stat = stat_reg;

endmodule

@@ rtl/core/weekly_relay_time_switch.sv @@
// top level of the weekly relay time switch: item handling, relay state and result register
//
// Each transaction is one item: a schedule entry write, a relay mode set or an evaluation at a
// weekday and minute, and each gives exactly one result. An evaluation walks the schedule
// memory through its single read port, checking each entry for its on and off events.
// Items are taken one at a time; a finished result waits in the output register while the
// next item is accepted. The schedule memory needs no clearing pass: entries never written
// read as disabled.
module weekly_relay_time_switch import wrs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_PUSH = 3'b100
    } top_state_t;

    top_state_t        state_reg, state_next;
    logic [1:0]        mode_reg [RELAYS];
    logic [1:0]        mode_next [RELAYS];
    logic [RELAYS-1:0] relay_state_reg, relay_state_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic              rd_valid_reg;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        day_reg;
    logic [10:0]       now_reg;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;

    logic              accept;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_entry;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [$bits(entry_t)-1:0] ram_q;
    entry_t            rd_entry;
    logic [RELAYS-1:0] auto_mode;
    logic [RELAYS-1:0] want_vec;
    scan_stat_t        stat;
    result_t           eval_res;
    result_t           plain_res;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    assign wr_en   = accept && (item.opcode == OP_WRITE) && (int'(item.relay) < RELAYS)
                     && (int'(item.slot) < SLOTS);
    assign wr_addr = AW'(int'(item.relay) * SLOTS + int'(item.slot));

    always_comb
    begin
        wr_entry.en   = item.entry_enabled;
        wr_entry.days = item.days_mask;
        wr_entry.sh   = item.start_hour;
        wr_entry.sm   = item.start_minute;
        wr_entry.eh   = item.stop_hour;
        wr_entry.em   = item.stop_minute;
    end

    wrs_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign rd_entry = rd_valid_reg ? entry_t'(ram_q) : '0;

    always_comb
    begin
        for (int i = 0; i < RELAYS; i++)
        begin
            auto_mode[i] = (mode_reg[i] != MODE_FORCE_OFF) && (mode_reg[i] != MODE_ON);
            want_vec[i]  = (mode_reg[i] == MODE_ON) || (auto_mode[i] && stat.want[i]);
        end
    end

    wrs_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && (item.opcode == OP_EVAL)),
        .day       (day_reg),
        .now       (now_reg),
        .auto_mode (auto_mode),
        .rd_entry  (rd_entry),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .stat      (stat)
    );

    always_comb
    begin
        eval_res                  = '0;
        eval_res.relay_on         = 4'(want_vec);
        eval_res.relay_changed    = 4'(want_vec ^ relay_state_reg);
        eval_res.event_valid      = stat.ev_valid;
        eval_res.event_relay      = stat.ev_relay;
        eval_res.event_turn_on    = stat.ev_on;
        eval_res.event_hour       = stat.ev_hour;
        eval_res.event_minute     = stat.ev_minute;
        eval_res.event_in_minutes = stat.ev_delta;
        plain_res                 = '0;
        plain_res.relay_on        = 4'(relay_state_reg);
    end

    always_comb
    begin
        state_next       = state_reg;
        relay_state_next = relay_state_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        mode_next        = mode_reg;
        valid_next       = valid_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        if (accept && (item.opcode == OP_MODE))
        begin
            for (int i = 0; i < RELAYS; i++)
            begin
                if (int'(item.relay) == i)
                begin
                    mode_next[i] = item.mode;
                end
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.opcode == OP_EVAL)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        res_next   = plain_res;
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.done)
                begin
                    relay_state_next = want_vec;
                    res_next         = eval_res;
                    state_next       = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            relay_state_reg <= '0;
            valid_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < RELAYS; i++)
            begin
                mode_reg[i] <= MODE_FORCE_OFF;
            end
        end
        else
        begin
            state_reg       <= state_next;
            relay_state_reg <= relay_state_next;
            valid_reg       <= valid_next;
            out_valid_reg   <= out_valid_next;
            mode_reg        <= mode_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            day_reg <= item.now_day;
            now_reg <= item.now_minute_of_day;
        end
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ dv/weekly_relay_time_switch_test.sv @@
// self-checking testbench of the weekly relay time switch with queue-fed driver and checking monitor
`timescale 1ns / 100ps

module weekly_relay_time_switch_test;
    import wrs_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 60;
    localparam int NO_EVENT     = 1000000;
    localparam int RANDOM_ITEMS = 900;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic       en;
        logic [6:0] days;
        logic [4:0] sh;
        logic [5:0] sm;
        logic [4:0] eh;
        logic [5:0] em;
    } window_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    window_t           windows [ENTRIES];
    logic [1:0]        modes [RELAYS];
    logic [RELAYS-1:0] relay_states;

    item_t   stim_items [$];
    int      stim_gaps [$];
    bit      stim_drain [$];
    result_t pending_results [$];

    int      idle_cnt;
    int      stall_cnt;
    int      cycle_cnt = 0;
    bit      failed    = 1'b0;
    result_t oldest;

    weekly_relay_time_switch DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic bit window_hits(window_t w, int day, int now);
        int a;
        int b;
        a = w.sh * 60 + w.sm;
        b = w.eh * 60 + w.em;
        if (!w.en || day >= 7 || a == b)
            return 1'b0;
        if (!w.days[day])
            return 1'b0;
        if (a < b)
            return (now >= a) && (now < b);
        return (now >= a) || (now < b);
    endfunction

    function automatic int next_switch_delta(int day, int now, int tgt, logic [6:0] mask);
        int d;
        int delta;
        if (mask == 7'd0)
            return -1;
        for (int off = 0; off <= 7; off++)
        begin
            d = (day + off) % 7;
            if (mask[d])
            begin
                delta = off * 1440 + tgt - now;
                if (delta > 0)
                    return delta;
            end
        end
        return -1;
    endfunction

    // updates the schedule, mode and relay copies and returns the result of one transaction
    function automatic result_t switch_outcome(item_t it);
        result_t   res;
        window_t   w;
        int        best;
        int        d;
        int        a;
        int        b;
        int        day;
        int        now;
        logic      want;
        logic [6:0] stop_days;
        res  = '0;
        best = NO_EVENT;
        case (it.opcode)
            OP_WRITE:
            begin
                w.en   = it.entry_enabled;
                w.days = it.days_mask;
                w.sh   = it.start_hour;
                w.sm   = it.start_minute;
                w.eh   = it.stop_hour;
                w.em   = it.stop_minute;
                windows[int'(it.relay) * SLOTS + int'(it.slot)] = w;
            end
            OP_MODE:
            begin
                modes[it.relay] = it.mode;
            end
            OP_EVAL:
            begin
                day = it.now_day;
                now = it.now_minute_of_day;
                for (int r = 0; r < RELAYS; r++)
                begin
                    want = 1'b0;
                    if (modes[r] == MODE_ON)
                        want = 1'b1;
                    else if (modes[r] >= MODE_SCHEDULED)
                    begin
                        for (int s = 0; s < SLOTS; s++)
                            if (window_hits(windows[r * SLOTS + s], day, now))
                                want = 1'b1;
                    end
                    if (want != relay_states[r])
                    begin
                        relay_states[r]     = want;
                        res.relay_changed[r] = 1'b1;
                    end
                end
                for (int r = 0; r < RELAYS; r++)
                begin
                    if (modes[r] >= MODE_SCHEDULED)
                    begin
                        for (int s = 0; s < SLOTS; s++)
                        begin
                            w = windows[r * SLOTS + s];
                            a = w.sh * 60 + w.sm;
                            b = w.eh * 60 + w.em;
                            if (w.en && a != b)
                            begin
                                d = next_switch_delta(day, now, a, w.days);
                                if (d > 0 && d < best)
                                begin
                                    best              = d;
                                    res.event_valid   = 1'b1;
                                    res.event_relay   = 2'(r);
                                    res.event_turn_on = 1'b1;
                                    res.event_hour    = w.sh;
                                    res.event_minute  = w.sm;
                                end
                                // midnight crossing moves the off edge to the next day
                                stop_days = (a > b) ? {w.days[5:0], w.days[6]} : w.days;
                                d = next_switch_delta(day, now, b, stop_days);
                                if (d > 0 && d < best)
                                begin
                                    best              = d;
                                    res.event_valid   = 1'b1;
                                    res.event_relay   = 2'(r);
                                    res.event_turn_on = 1'b0;
                                    res.event_hour    = w.eh;
                                    res.event_minute  = w.em;
                                end
                            end
                        end
                    end
                end
                if (res.event_valid)
                    res.event_in_minutes = 14'(best);
            end
            default:
            begin
            end
        endcase
        res.relay_on = relay_states;
        return res;
    endfunction

    function automatic item_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic item_t make_write(int r, int s, bit en, int days, int sh, int sm,
                                         int eh, int em);
        item_t it;
        it               = random_item();
        it.opcode        = OP_WRITE;
        it.relay         = 2'(r);
        it.slot          = 2'(s);
        it.entry_enabled = en;
        it.days_mask     = 7'(days);
        it.start_hour    = 5'(sh);
        it.start_minute  = 6'(sm);
        it.stop_hour     = 5'(eh);
        it.stop_minute   = 6'(em);
        return it;
    endfunction

    function automatic item_t make_mode(int r, logic [1:0] m);
        item_t it;
        it        = random_item();
        it.opcode = OP_MODE;
        it.relay  = 2'(r);
        it.mode   = m;
        return it;
    endfunction

    function automatic item_t make_eval(int day, int now);
        item_t it;
        it                   = random_item();
        it.opcode            = OP_EVAL;
        it.now_day           = 3'(day);
        it.now_minute_of_day = 11'(now);
        return it;
    endfunction

    task automatic add_item(item_t it, int gap, bit drain);
        stim_items.push_back(it);
        stim_gaps.push_back(gap);
        stim_drain.push_back(drain);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            idle_cnt    = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                pending_results.push_back(switch_outcome(item));
            if (!item_valid || !item_stall)
            begin
                if (stim_items.size() > 0 && idle_cnt >= stim_gaps[0] &&
                    !(stim_drain[0] && pending_results.size() > 0))
                begin
                    item       <= stim_items.pop_front();
                    item_valid <= 1'b1;
                    void'(stim_gaps.pop_front());
                    void'(stim_drain.pop_front());
                    idle_cnt    = 0;
                end
                else
                begin
                    item_valid <= 1'b0;
                    if (stim_items.size() > 0)
                        idle_cnt++;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_cnt     = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    failed = 1'b1;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("relay_on", oldest.relay_on, result.relay_on);
                    check_field("relay_changed", oldest.relay_changed, result.relay_changed);
                    check_field("event_valid", oldest.event_valid, result.event_valid);
                    check_field("event_relay", oldest.event_relay, result.event_relay);
                    check_field("event_turn_on", oldest.event_turn_on, result.event_turn_on);
                    check_field("event_hour", oldest.event_hour, result.event_hour);
                    check_field("event_minute", oldest.event_minute, result.event_minute);
                    check_field("event_in_minutes", oldest.event_in_minutes,
                                result.event_in_minutes);
                end
            end
            if (stall_cnt == 0 && (cycle_cnt % 2000) >= 400 && $urandom_range(0, 99) < 20)
                stall_cnt = idle_len();
            if (stall_cnt > 0)
            begin
                result_stall <= 1'b1;
                stall_cnt--;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("weekly_relay_time_switch verification failed");
        $finish;
    end

    initial
    begin
        item_t it;
        int    added;
        int    pick;
        int    r;
        int    a;
        int    b;
        int    sh;
        int    sm;
        int    eh;
        int    em;
        int    now;
        int    day;
        bit    calm;
        int    bounds [$];

        for (int e = 0; e < ENTRIES; e++)
            windows[e] = '0;
        for (int k = 0; k < RELAYS; k++)
            modes[k] = MODE_FORCE_OFF;
        relay_states = '0;

        add_item(make_eval(0, 0), 0, 1'b0);
        add_item(make_mode(0, MODE_ON), 0, 1'b0);
        add_item(make_eval(3, 720), 2, 1'b0);
        add_item(make_write(1, 0, 1'b1, 7'h7F, 8, 0, 17, 30), 0, 1'b0);
        add_item(make_mode(1, MODE_SCHEDULED), 0, 1'b0);
        add_item(make_eval(1, 480), 0, 1'b0);
        add_item(make_eval(1, 1050), 5, 1'b0);
        add_item(make_eval(6, 1439), 0, 1'b0);
        // window across midnight on sunday only
        add_item(make_write(2, 3, 1'b1, 7'h01, 22, 0, 6, 0), 0, 1'b0);
        add_item(make_mode(2, MODE_SPARE), 1, 1'b0);
        add_item(make_eval(0, 1400), 0, 1'b0);
        add_item(make_eval(1, 100), 0, 1'b0);
        add_item(make_eval(6, 1380), 0, 1'b0);
        // equal start and stop
        add_item(make_write(3, 1, 1'b1, 7'h7F, 12, 0, 12, 0), 0, 1'b0);
        add_item(make_mode(3, MODE_SCHEDULED), 0, 1'b0);
        add_item(make_eval(2, 600), 0, 1'b0);
        // ties between relays and slots
        add_item(make_write(3, 2, 1'b1, 7'h7F, 8, 0, 17, 30), 0, 1'b0);
        add_item(make_write(1, 2, 1'b1, 7'h7F, 8, 0, 17, 30), 0, 1'b0);
        add_item(make_eval(2, 300), 3, 1'b0);
        add_item(make_write(1, 1, 1'b0, 7'h7F, 9, 0, 10, 0), 0, 1'b0);
        add_item(make_write(0, 1, 1'b1, 7'h00, 5, 0, 7, 0), 0, 1'b0);
        // times beyond their normal range
        add_item(make_write(1, 3, 1'b1, 7'h7F, 31, 63, 31, 0), 0, 1'b0);
        add_item(make_eval(7, 2047), 0, 1'b0);
        add_item(make_eval(5, 1439), 0, 1'b0);
        it        = random_item();
        it.opcode = OP_NONE;
        add_item(it, 0, 1'b0);
        add_item(make_mode(0, MODE_FORCE_OFF), 0, 1'b0);
        add_item(make_eval(0, 0), 0, 1'b0);

        calm = 1'b0;
        bounds.push_back(480);
        for (added = 0; added < RANDOM_ITEMS; added++)
        begin
            if (added % 64 == 0)
                calm = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                it = random_item();
            end
            else if (pick < 35)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    sh = $urandom_range(0, 31);
                    sm = $urandom_range(0, 63);
                    eh = $urandom_range(0, 31);
                    em = $urandom_range(0, 63);
                end
                else
                begin
                    sh = $urandom_range(0, 23);
                    sm = $urandom_range(0, 59);
                    eh = $urandom_range(0, 23);
                    em = $urandom_range(0, 59);
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    eh = sh;
                    em = sm;
                end
                it = make_write($urandom_range(0, 3), $urandom_range(0, 3),
                                $urandom_range(0, 9) != 0,
                                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127),
                                sh, sm, eh, em);
                a = sh * 60 + sm;
                b = eh * 60 + em;
                bounds.push_back(a);
                bounds.push_back(b);
                while (bounds.size() > 16)
                    void'(bounds.pop_front());
            end
            else if (pick < 45)
            begin
                it = make_mode($urandom_range(0, 3),
                               ($urandom_range(0, 9) < 7) ? MODE_SCHEDULED
                                                          : 2'($urandom_range(0, 3)));
            end
            else
            begin
                day = ($urandom_range(0, 29) == 0) ? 7 : $urandom_range(0, 6);
                r   = $urandom_range(0, 99);
                if (r < 60)
                    now = (bounds[$urandom_range(0, bounds.size() - 1)] + 1438 +
                           $urandom_range(0, 4)) % 1440;
                else if (r < 95)
                    now = $urandom_range(0, 1439);
                else
                    now = $urandom_range(0, 2047);
                it = make_eval(day, now);
            end
            add_item(it, calm ? 0 : idle_len(), (added % 250) == 0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_items.size() > 0 || item_valid || pending_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (!failed && pending_results.size() == 0)
            $display("weekly_relay_time_switch verification clean");
        else
            $display("weekly_relay_time_switch verification failed");
        $finish;
    end

endmodule
